// File: rtl/core/qtpb_pkg.sv
// Shared constants, types and helpers of the quadtree point binning core.
package qtpb_pkg;

  localparam int unsigned TREE_LAYERS = 5;
  localparam int unsigned COUNT_BITS  = 16;

  localparam int unsigned NODES      = ((1 << (2 * TREE_LAYERS)) - 1) / 3;
  localparam int unsigned LEAF_START = ((1 << (2 * (TREE_LAYERS - 1))) - 1) / 3;
  localparam int unsigned NODE_W     = ($clog2(NODES) < 3) ? 3 : $clog2(NODES);

  localparam int unsigned COORD_W  = 32;
  localparam int unsigned SPREAD_W = 29;
  localparam int unsigned INDEX_W  = 9;
  localparam int unsigned CNT_OUT_W = 16;
  localparam int unsigned CFG_ADDR_W = 2;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  localparam logic signed [COORD_W-1:0] RST_MIN_LON = -32'sd11796480;
  localparam logic signed [COORD_W-1:0] RST_MAX_LON =  32'sd11796480;
  localparam logic signed [COORD_W-1:0] RST_MIN_LAT = -32'sd5898240;
  localparam logic signed [COORD_W-1:0] RST_MAX_LAT =  32'sd5898240;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_MIN_LON = 2'd0,
    CFG_MAX_LON = 2'd1,
    CFG_MIN_LAT = 2'd2,
    CFG_MAX_LAT = 2'd3
  } cfg_reg_e;

  // Controller to datapath
  typedef struct packed {
    logic              clr_en;
    logic [NODE_W-1:0] clr_addr;
    logic              load;
    logic              step;
    logic              rd_en;
    logic              upd;
  } qtpb_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic stop;
  } qtpb_status_t;

  function automatic logic [CNT_OUT_W-1:0] count_out(input logic [COUNT_BITS-1:0] c);
    logic [31:0] w;
    w = 32'(c);
    return w[CNT_OUT_W-1:0];
  endfunction

  function automatic logic [INDEX_W-1:0] index_out(input logic [NODE_W-1:0] n);
    logic [31:0] w;
    w = 32'(n);
    return w[INDEX_W-1:0];
  endfunction

endpackage

// File: rtl/core/qtpb_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module qtpb_ram #(
  parameter int unsigned WIDTH  = 16,
  parameter int unsigned DEPTH  = 341,
  parameter int unsigned ADDR_W = 9
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/qtpb_ctrl.sv
// Sequencing controller: clearing pass, tree walk, count update, output flag.
module qtpb_ctrl
  import qtpb_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  input  qtpb_status_t status_i,
  output qtpb_cmd_t    cmd_o
);

  localparam logic [2:0] S_CLEAR   = 3'd0;
  localparam logic [2:0] S_IDLE    = 3'd1;
  localparam logic [2:0] S_DESCEND = 3'd2;
  localparam logic [2:0] S_UPDATE  = 3'd3;

  localparam logic [NODE_W-1:0] LAST_NODE = NODE_W'(NODES - 1);

  logic [2:0]        state_q, state_d;
  logic [NODE_W-1:0] clr_cnt_q, clr_cnt_d;
  logic              out_valid_q, out_valid_d;

  always_comb begin
    state_d   = state_q;
    clr_cnt_d = clr_cnt_q;
    cmd_o     = '0;
    in_ready_o = 1'b0;
    cmd_o.clr_addr = clr_cnt_q;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_en = 1'b1;
        clr_cnt_d = clr_cnt_q + NODE_W'(1);
        if (clr_cnt_q == LAST_NODE) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = S_DESCEND;
        end
      end
      S_DESCEND: begin
        cmd_o.step = 1'b1;
        if (status_i.stop) begin
          cmd_o.rd_en = 1'b1;
          state_d = S_UPDATE;
        end
      end
      S_UPDATE: begin
        // wait for a free output register before committing
        if (!out_valid_q || out_ready_i) begin
          cmd_o.upd = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.upd) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_accept_walks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_DESCEND))
    else $error("accepted item did not start the tree walk");

  a_clear_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_CLEAR) |=> (state_q != S_CLEAR))
    else $error("clearing pass re-entered");

  a_read_then_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.rd_en |=> (state_q == S_UPDATE))
    else $error("count read not followed by update");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o)
    else $error("pending result dropped");

endmodule

// File: rtl/core/qtpb_dp.sv
// Datapath: configuration registers, per-level quadrant test, count RAM and result register.
module qtpb_dp
  import qtpb_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [CFG_ADDR_W-1:0]      cfg_addr_i,
  input  logic [COORD_W-1:0]         cfg_wdata_i,
  input  logic signed [COORD_W-1:0]  point_lon_i,
  input  logic signed [COORD_W-1:0]  point_lat_i,
  input  logic [SPREAD_W-1:0]        point_spread_i,
  input  qtpb_cmd_t                  cmd_i,
  output qtpb_status_t               status_o,
  output logic [INDEX_W-1:0]         node_index_o,
  output logic [CNT_OUT_W-1:0]       node_count_o,
  output logic                       at_leaf_o
);

  localparam int unsigned EXT_W = COORD_W + 2;

  function automatic logic signed [EXT_W-1:0] sx(input logic signed [COORD_W-1:0] v);
    return EXT_W'(v);
  endfunction

  function automatic logic signed [COORD_W-1:0] mid(input logic signed [COORD_W-1:0] a,
                                                   input logic signed [COORD_W-1:0] b);
    logic signed [COORD_W:0] s;
    s = (COORD_W+1)'(a) + (COORD_W+1)'(b);
    return s[COORD_W:1];
  endfunction

  // configuration
  logic signed [COORD_W-1:0] min_lon_q, max_lon_q, min_lat_q, max_lat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_lon_q <= RST_MIN_LON;
      max_lon_q <= RST_MAX_LON;
      min_lat_q <= RST_MIN_LAT;
      max_lat_q <= RST_MAX_LAT;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_addr_i))
        CFG_MIN_LON: min_lon_q <= cfg_wdata_i;
        CFG_MAX_LON: max_lon_q <= cfg_wdata_i;
        CFG_MIN_LAT: min_lat_q <= cfg_wdata_i;
        CFG_MAX_LAT: max_lat_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // point extents, fixed for the whole walk
  logic signed [EXT_W-1:0] lon_p_q, lon_m_q, lat_p_q, lat_m_q;
  logic [COORD_W-2:0]      r3;
  logic signed [EXT_W-1:0] r_ext;

  assign r3    = (COORD_W-1)'({point_spread_i, 1'b0}) + (COORD_W-1)'(point_spread_i);
  assign r_ext = $signed(EXT_W'(r3));

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      lon_p_q <= sx(point_lon_i) + r_ext;
      lon_m_q <= sx(point_lon_i) - r_ext;
      lat_p_q <= sx(point_lat_i) + r_ext;
      lat_m_q <= sx(point_lat_i) - r_ext;
    end
  end

  // current node and its region
  logic signed [COORD_W-1:0] lo_lon_q, hi_lon_q, lo_lat_q, hi_lat_q;
  logic [NODE_W-1:0]         node_q;
  logic signed [COORD_W-1:0] mid_lon, mid_lat;
  logic lon_lo_fit, lon_hi_fit, lat_lo_fit, lat_hi_fit;
  logic [3:0] fit;
  logic [1:0] quad;
  logic       any_fit, is_leaf;

  assign mid_lon = mid(lo_lon_q, hi_lon_q);
  assign mid_lat = mid(lo_lat_q, hi_lat_q);

  assign lon_lo_fit = (lon_p_q <= sx(mid_lon))  && (lon_m_q >= sx(lo_lon_q));
  assign lon_hi_fit = (lon_p_q <= sx(hi_lon_q)) && (lon_m_q >= sx(mid_lon));
  assign lat_lo_fit = (lat_p_q <= sx(mid_lat))  && (lat_m_q >= sx(lo_lat_q));
  assign lat_hi_fit = (lat_p_q <= sx(hi_lat_q)) && (lat_m_q >= sx(mid_lat));

  assign fit = {lon_hi_fit & lat_hi_fit, lon_lo_fit & lat_hi_fit,
                lon_hi_fit & lat_lo_fit, lon_lo_fit & lat_lo_fit};

  // first fitting quadrant wins
  always_comb begin
    quad = 2'd3;
    if (fit[0]) begin
      quad = 2'd0;
    end else if (fit[1]) begin
      quad = 2'd1;
    end else if (fit[2]) begin
      quad = 2'd2;
    end
  end

  assign any_fit = |fit;
  assign is_leaf = (node_q >= NODE_W'(LEAF_START));
  assign status_o.stop = is_leaf || !any_fit;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      node_q   <= '0;
      lo_lon_q <= min_lon_q;
      hi_lon_q <= max_lon_q;
      lo_lat_q <= min_lat_q;
      hi_lat_q <= max_lat_q;
    end else if (cmd_i.step && !status_o.stop) begin
      node_q <= {node_q[NODE_W-3:0], 2'b00} + NODE_W'(quad) + NODE_W'(1);
      if (quad[0]) begin
        lo_lon_q <= mid_lon;
      end else begin
        hi_lon_q <= mid_lon;
      end
      if (quad[1]) begin
        lo_lat_q <= mid_lat;
      end else begin
        hi_lat_q <= mid_lat;
      end
    end
  end

  // count memory: read while walk stops, write back on update
  logic [COUNT_BITS-1:0] cnt_rd, cnt_inc, ram_wdata;
  logic [NODE_W-1:0]     ram_waddr;
  logic                  ram_we;

  assign cnt_inc   = (cnt_rd == COUNT_MAX) ? cnt_rd : cnt_rd + COUNT_BITS'(1);
  assign ram_we    = cmd_i.clr_en || cmd_i.upd;
  assign ram_waddr = cmd_i.clr_en ? cmd_i.clr_addr : node_q;
  assign ram_wdata = cmd_i.clr_en ? '0 : cnt_inc;

  qtpb_ram #(
    .WIDTH  (COUNT_BITS),
    .DEPTH  (NODES),
    .ADDR_W (NODE_W)
  ) u_count_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.rd_en),
    .raddr_i (node_q),
    .rdata_o (cnt_rd)
  );

  // result register
  logic [INDEX_W-1:0]   node_index_q;
  logic [CNT_OUT_W-1:0] node_count_q;
  logic                 at_leaf_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.upd) begin
      node_index_q <= index_out(node_q);
      node_count_q <= count_out(cnt_inc);
      at_leaf_q    <= is_leaf;
    end
  end

  assign node_index_o = node_index_q;
  assign node_count_o = node_count_q;
  assign at_leaf_o    = at_leaf_q;

endmodule

// File: rtl/core/quadtree_point_binning_core.sv
// Top level of the quadtree point binning core: controller plus datapath.
//
// Bins points into a complete quadtree of TREE_LAYERS levels (341 nodes for
// five levels) laid over the box held in the four bound registers (signed
// Q16.16, written through cfg_we_i/cfg_addr_i/cfg_wdata_i while idle). Each
// item walks down from the root, one tree level per cycle, into the first
// child quadrant (low/low, high/low, low/high, high/high in lon/lat) that
// fully contains the square of half-width 3*point_spread; it stops at a leaf
// or where no child fits. That node's saturating count is then bumped in a
// count RAM with one write and one read port, and the node index, new count
// and leaf flag come out as one result item. An item goes through accept,
// the level walk and a read-modify-write update of its node's count. After
// reset the count RAM is zeroed by a clearing pass over all 341 nodes, during
// which no item is accepted. Results sit in an output register, so a waiting
// result does not hold up the next item's walk.
module quadtree_point_binning_core
  import qtpb_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // configuration
  input  logic                      cfg_we_i,
  input  logic [CFG_ADDR_W-1:0]     cfg_addr_i,
  input  logic [COORD_W-1:0]        cfg_wdata_i,
  // input items
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic signed [COORD_W-1:0] point_lon_i,
  input  logic signed [COORD_W-1:0] point_lat_i,
  input  logic [SPREAD_W-1:0]       point_spread_i,
  // result items
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [INDEX_W-1:0]        node_index_o,
  output logic [CNT_OUT_W-1:0]      node_count_o,
  output logic                      at_leaf_o
);

  qtpb_cmd_t    cmd;
  qtpb_status_t status;

  // sequencing: clear pass, walk, update, output handshake
  qtpb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // region arithmetic, count memory, result register
  qtpb_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_addr_i     (cfg_addr_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .point_lon_i    (point_lon_i),
    .point_lat_i    (point_lat_i),
    .point_spread_i (point_spread_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .node_index_o   (node_index_o),
    .node_count_o   (node_count_o),
    .at_leaf_o      (at_leaf_o)
  );

endmodule
